// ===== rtl/cihf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cihf_pkg;

  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_SAMPLE_BITS = 16;
  // Fraction bits of the repaired heights
  localparam int Q_BITS          = 8;
  // Growth of a repaired height over two extrapolation passes
  localparam int REP_HEAD        = 3;
  // Growth of the cubic coefficients and partial sums over a repaired height
  localparam int COEF_HEAD       = 5;
  localparam int MIN_VALID_RESET = -32000;

  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_A_EXT,
    RULE_B_MID,
    RULE_B_EXT,
    RULE_C_MID,
    RULE_C_EXT,
    RULE_D_EXT
  } rule_t;

  // First matching repair rule; ok[0..3] flag samples a..d as valid
  function automatic rule_t pick_rule(input logic [3:0] ok);
    rule_t r;
    priority if (!ok[0] && ok[1] && ok[2]) begin
      r = RULE_A_EXT;
    end else if (!ok[1] && ok[0] && ok[2]) begin
      r = RULE_B_MID;
    end else if (!ok[1] && ok[2] && ok[3]) begin
      r = RULE_B_EXT;
    end else if (!ok[2] && ok[1] && ok[3]) begin
      r = RULE_C_MID;
    end else if (!ok[2] && ok[0] && ok[1]) begin
      r = RULE_C_EXT;
    end else if (!ok[3] && ok[1] && ok[2]) begin
      r = RULE_D_EXT;
    end else begin
      r = RULE_NONE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cihf_pass.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cihf_pass #(
  parameter int HW = cihf_pkg::DEF_SAMPLE_BITS + cihf_pkg::Q_BITS + cihf_pkg::REP_HEAD,
  parameter int SW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      ready,
  input  wire logic                 ready_next,
  input  wire logic signed [HW-1:0] thr,
  input  wire logic [3:0][HW-1:0]   h_in,
  input  wire logic [3:0]           ok_in,
  input  wire logic [SW-1:0]        side_in,
  output logic                      out_valid,
  output logic [3:0][HW-1:0]        h_out,
  output logic [3:0]                ok_out,
  output logic [SW-1:0]             side_out
);
  import cihf_pkg::*;

  rule_t                  rule;
  logic [1:0]             idx;
  logic                   is_mid;
  logic signed [HW+1:0]   op_p;
  logic signed [HW+1:0]   op_q;
  logic signed [HW+1:0]   ext_v;
  logic signed [HW+1:0]   mid_sum;
  logic signed [HW+1:0]   mid_v;
  logic signed [HW-1:0]   new_v;
  logic                   new_ok;
  logic [3:0][HW-1:0]     h_next;
  logic [3:0]             ok_next;

  always_comb begin
    rule   = pick_rule(ok_in);
    is_mid = (rule == RULE_B_MID) || (rule == RULE_C_MID);
    unique case (rule)
      RULE_A_EXT: begin
        idx  = 2'd0;
        op_p = (HW+2)'($signed(h_in[1]));
        op_q = (HW+2)'($signed(h_in[2]));
      end
      RULE_B_MID: begin
        idx  = 2'd1;
        op_p = (HW+2)'($signed(h_in[0]));
        op_q = (HW+2)'($signed(h_in[2]));
      end
      RULE_B_EXT: begin
        idx  = 2'd1;
        op_p = (HW+2)'($signed(h_in[2]));
        op_q = (HW+2)'($signed(h_in[3]));
      end
      RULE_C_MID: begin
        idx  = 2'd2;
        op_p = (HW+2)'($signed(h_in[1]));
        op_q = (HW+2)'($signed(h_in[3]));
      end
      RULE_C_EXT: begin
        idx  = 2'd2;
        op_p = (HW+2)'($signed(h_in[1]));
        op_q = (HW+2)'($signed(h_in[0]));
      end
      RULE_D_EXT: begin
        idx  = 2'd3;
        op_p = (HW+2)'($signed(h_in[2]));
        op_q = (HW+2)'($signed(h_in[1]));
      end
      default: begin
        idx  = 2'd0;
        op_p = '0;
        op_q = '0;
      end
    endcase
    ext_v   = (op_p <<< 1) - op_q;
    mid_sum = op_p + op_q;
    // halve toward zero: bias negative sums by one before the shift
    mid_v   = (mid_sum + $signed({{(HW+1){1'b0}}, mid_sum[HW+1]})) >>> 1;
    new_v   = is_mid ? HW'(mid_v) : HW'(ext_v);
    new_ok  = new_v > thr;
    h_next  = h_in;
    ok_next = ok_in;
    if (rule != RULE_NONE) begin
      h_next[idx]  = new_v;
      ok_next[idx] = new_ok;
    end
  end

  assign ready = !out_valid || ready_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      h_out    <= h_next;
      ok_out   <= ok_next;
      side_out <= side_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cihf_repair.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cihf_repair #(
  parameter int SAMPLE_BITS = cihf_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = cihf_pkg::DEF_FRAC_BITS,
  localparam int HW = SAMPLE_BITS + cihf_pkg::Q_BITS + cihf_pkg::REP_HEAD
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               ready,
  input  wire logic                          ready_next,
  input  wire logic signed [SAMPLE_BITS-1:0] threshold,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_a,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_b,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_c,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_d,
  input  wire logic [FRAC_BITS-1:0]          frac,
  output logic                               out_valid,
  output logic [3:0][HW-1:0]                 h_out,
  output logic [FRAC_BITS-1:0]               frac_out
);
  import cihf_pkg::*;

  // 2a+d and a+2d, and the divide-by-three reciprocal for their magnitudes
  localparam int XW   = SAMPLE_BITS + 2;
  localparam int NB   = SAMPLE_BITS + 1;
  localparam int KD   = ((NB + 1) % 2 == 0) ? NB + 1 : NB + 2;
  localparam int PXW  = NB + KD;
  localparam logic [KD-1:0] RECIP = KD'(((64'd1 << KD) + 64'd2) / 64'd3);
  localparam logic signed [HW-1:0] K85 = HW'(85);
  localparam int SW1  = 1 + 2 * XW + 2 * PXW + FRAC_BITS;
  localparam int SW2  = 1 + 2 * HW + FRAC_BITS;

  logic signed [HW-1:0]   thr;

  // input stage
  logic                   v1;
  logic                   rdy1;
  logic [3:0][HW-1:0]     h1;
  logic [3:0]             ok1;
  logic signed [XW-1:0]   x1;
  logic signed [XW-1:0]   y1;
  logic                   flag1;
  logic [FRAC_BITS-1:0]   frac1;

  logic [NB-1:0]          mag_x;
  logic [NB-1:0]          mag_y;
  logic [PXW-1:0]         prod_x;
  logic [PXW-1:0]         prod_y;
  logic [SW1-1:0]         side1_in;

  // first pass
  logic                   p1_ready;
  logic                   p1_valid;
  logic [3:0][HW-1:0]     p1_h;
  logic [3:0]             p1_ok;
  logic [SW1-1:0]         side1_out;
  logic                   s1_flag;
  logic signed [XW-1:0]   s1_x;
  logic signed [XW-1:0]   s1_y;
  logic [PXW-1:0]         s1_px;
  logic [PXW-1:0]         s1_py;
  logic [FRAC_BITS-1:0]   s1_frac;
  logic signed [HW-1:0]   q_x;
  logic signed [HW-1:0]   q_y;
  logic signed [HW-1:0]   third_a;
  logic signed [HW-1:0]   third_b;
  logic [SW2-1:0]         side2_in;

  // second pass
  logic                   p2_ready;
  logic [3:0][HW-1:0]     p2_h;
  logic [3:0]             p2_ok;
  logic [SW2-1:0]         side2_out;
  logic                   s2_flag;
  logic signed [HW-1:0]   s2_a;
  logic signed [HW-1:0]   s2_b;

  assign thr  = HW'($signed({threshold, {Q_BITS{1'b0}}}));
  assign rdy1 = !v1 || p1_ready;
  assign ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      h1[0] <= HW'($signed({sample_a, {Q_BITS{1'b0}}}));
      h1[1] <= HW'($signed({sample_b, {Q_BITS{1'b0}}}));
      h1[2] <= HW'($signed({sample_c, {Q_BITS{1'b0}}}));
      h1[3] <= HW'($signed({sample_d, {Q_BITS{1'b0}}}));
      ok1   <= {sample_d > threshold, sample_c > threshold,
                sample_b > threshold, sample_a > threshold};
      // an interior gap is never touched by the passes, so decide it here
      flag1 <= (sample_a > threshold) && (sample_d > threshold) &&
               !(sample_b > threshold) && !(sample_c > threshold);
      x1    <= (XW'(sample_a) <<< 1) + XW'(sample_d);
      y1    <= XW'(sample_a) + (XW'(sample_d) <<< 1);
      frac1 <= frac;
    end
  end

  // 256x/3 = 85x + x/3; take x/3 on the magnitude by reciprocal
  always_comb begin
    mag_x    = x1[XW-1] ? NB'(-x1) : NB'(x1);
    mag_y    = y1[XW-1] ? NB'(-y1) : NB'(y1);
    prod_x   = PXW'(mag_x) * PXW'(RECIP);
    prod_y   = PXW'(mag_y) * PXW'(RECIP);
    side1_in = {flag1, x1, y1, prod_x, prod_y, frac1};
  end

  cihf_pass #(.HW(HW), .SW(SW1)) u_pass1 (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v1),
    .ready      (p1_ready),
    .ready_next (p2_ready),
    .thr        (thr),
    .h_in       (h1),
    .ok_in      (ok1),
    .side_in    (side1_in),
    .out_valid  (p1_valid),
    .h_out      (p1_h),
    .ok_out     (p1_ok),
    .side_out   (side1_out)
  );

  assign {s1_flag, s1_x, s1_y, s1_px, s1_py, s1_frac} = side1_out;

  always_comb begin
    q_x      = $signed(HW'(s1_px[PXW-1:KD]));
    q_y      = $signed(HW'(s1_py[PXW-1:KD]));
    third_a  = HW'(s1_x) * K85 + (s1_x[XW-1] ? -q_x : q_x);
    third_b  = HW'(s1_y) * K85 + (s1_y[XW-1] ? -q_y : q_y);
    side2_in = {s1_flag, third_a, third_b, s1_frac};
  end

  cihf_pass #(.HW(HW), .SW(SW2)) u_pass2 (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (p1_valid),
    .ready      (p2_ready),
    .ready_next (ready_next),
    .thr        (thr),
    .h_in       (p1_h),
    .ok_in      (p1_ok),
    .side_in    (side2_in),
    .out_valid  (out_valid),
    .h_out      (p2_h),
    .ok_out     (p2_ok),
    .side_out   (side2_out)
  );

  assign {s2_flag, s2_a, s2_b, frac_out} = side2_out;

  always_comb begin
    h_out = p2_h;
    if (s2_flag) begin
      h_out[1] = s2_a;
      h_out[2] = s2_b;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cihf_cubic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cihf_cubic #(
  parameter int SAMPLE_BITS = cihf_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = cihf_pkg::DEF_FRAC_BITS,
  localparam int HW = SAMPLE_BITS + cihf_pkg::Q_BITS + cihf_pkg::REP_HEAD,
  localparam int CW = HW + cihf_pkg::COEF_HEAD
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      ready,
  input  wire logic                 ready_next,
  input  wire logic [3:0][HW-1:0]   h,
  input  wire logic [FRAC_BITS-1:0] frac,
  output logic                      out_valid,
  output logic signed [CW-1:0]      sum
);
  import cihf_pkg::*;

  localparam int NST = 7;
  localparam int PW  = CW + FRAC_BITS + 1;

  logic [NST-1:0]       v;
  logic [NST-1:0]       rdy;

  logic signed [CW-1:0] e0, e1, e2, e3, d12;

  logic signed [CW-1:0] c3_0, c2_0, c1_0, b2_0;
  logic [FRAC_BITS-1:0] u0;
  logic signed [PW-1:0] p1;
  logic signed [CW-1:0] c2_1, c1_1, b2_1;
  logic [FRAC_BITS-1:0] u1;
  logic signed [CW-1:0] t_2, c1_2, b2_2;
  logic [FRAC_BITS-1:0] u2;
  logic signed [PW-1:0] p2;
  logic signed [CW-1:0] c1_3, b2_3;
  logic [FRAC_BITS-1:0] u3;
  logic signed [CW-1:0] t2_4, b2_4;
  logic [FRAC_BITS-1:0] u4;
  logic signed [PW-1:0] p3;
  logic signed [CW-1:0] b2_5;

  // v * u / 2^FRAC_BITS, truncated toward zero
  function automatic logic signed [CW-1:0] trunc_frac(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = p >>> FRAC_BITS;
    if (p[PW-1] && (p[FRAC_BITS-1:0] != '0)) begin
      q = q + $signed(PW'(1));
    end
    return CW'(q);
  endfunction

  always_comb begin
    rdy[NST-1] = !v[NST-1] || ready_next;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign ready     = rdy[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_comb begin
    e0  = CW'($signed(h[0]));
    e1  = CW'($signed(h[1]));
    e2  = CW'($signed(h[2]));
    e3  = CW'($signed(h[3]));
    d12 = e1 - e2;
  end

  // coefficients
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c3_0 <= (d12 <<< 1) + d12 + e3 - e0;
      c2_0 <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      c1_0 <= e2 - e0;
      b2_0 <= e1 <<< 1;
      u0   <= frac;
    end
  end

  // c3 * u
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p1   <= PW'(c3_0) * PW'($signed({1'b0, u0}));
      c2_1 <= c2_0;
      c1_1 <= c1_0;
      b2_1 <= b2_0;
      u1   <= u0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      t_2  <= c2_1 + trunc_frac(p1);
      c1_2 <= c1_1;
      b2_2 <= b2_1;
      u2   <= u1;
    end
  end

  // t * u
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      p2   <= PW'(t_2) * PW'($signed({1'b0, u2}));
      c1_3 <= c1_2;
      b2_3 <= b2_2;
      u3   <= u2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      t2_4 <= c1_3 + trunc_frac(p2);
      b2_4 <= b2_3;
      u4   <= u3;
    end
  end

  // t2 * u
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      p3   <= PW'(t2_4) * PW'($signed({1'b0, u4}));
      b2_5 <= b2_4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      sum <= b2_5 + trunc_frac(p3);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cubic_interp_with_hole_fill_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle while height_stall stays low; the three
// multiplies of the cubic each sit in a stage of their own, so nothing loops back.
// Reset (synchronous, active high): all valid flags clear, the pipeline empties
// and the threshold register returns to -32000.
module cubic_interp_with_hole_fill_top #(
  parameter int FRAC_BITS   = cihf_pkg::DEF_FRAC_BITS,
  parameter int SAMPLE_BITS = cihf_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_a,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_b,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_c,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_d,
  input  wire logic [FRAC_BITS-1:0]          frac,
  // result channel
  output logic                               height_valid,
  input  wire logic                          height_stall,
  output logic signed [SAMPLE_BITS-1:0]      height,
  // threshold write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] min_valid
);
  import cihf_pkg::*;

  localparam int HW = SAMPLE_BITS + Q_BITS + REP_HEAD;
  localparam int CW = HW + COEF_HEAD;
  localparam int SH = Q_BITS + 1;
  localparam logic signed [CW-1:0] HI_LIM = CW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] LO_LIM = -HI_LIM - CW'(1);

  logic signed [SAMPLE_BITS-1:0] threshold;

  logic                          rep_ready;
  logic                          rep_valid;
  logic [3:0][HW-1:0]            rep_h;
  logic [FRAC_BITS-1:0]          rep_frac;

  logic                          cub_ready;
  logic                          cub_valid;
  logic signed [CW-1:0]          cub_sum;

  logic                          out_ready;
  logic signed [CW-1:0]          scaled;
  logic signed [SAMPLE_BITS-1:0] height_next;

  // The threshold register takes a write on any cycle; writes must only be made by the user
  // while no request is in flight, so every stage sees one stable value; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= SAMPLE_BITS'(MIN_VALID_RESET);
    end else if (cfg_valid) begin
      threshold <= min_valid;
    end
  end

  // Hole repair: an input register, then two priority-rule passes. The
  // interior-gap thirds are built alongside the passes and override b and c
  // at the end where the gap applies.
  cihf_repair #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_repair (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sample_valid),
    .ready      (rep_ready),
    .ready_next (cub_ready),
    .threshold  (threshold),
    .sample_a   (sample_a),
    .sample_b   (sample_b),
    .sample_c   (sample_c),
    .sample_d   (sample_d),
    .frac       (frac),
    .out_valid  (rep_valid),
    .h_out      (rep_h),
    .frac_out   (rep_frac)
  );

  assign sample_stall = !rep_ready;

  // Catmull-Rom evaluation in Horner form: coefficients, then three
  // multiply / truncate-and-add stage pairs, ending in 2b + s (Q.8, doubled).
  cihf_cubic #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cubic (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rep_valid),
    .ready      (cub_ready),
    .ready_next (out_ready),
    .h          (rep_h),
    .frac       (rep_frac),
    .out_valid  (cub_valid),
    .sum        (cub_sum)
  );

  // Output register: drop the doubling and the Q.8 fraction with a
  // truncation toward zero, then clamp to the sample range. It parts the
  // pipeline from the consumer: a held result still lets earlier stages
  // advance into any bubble ahead of it.
  assign out_ready = !height_valid || !height_stall;

  always_comb begin
    scaled = cub_sum >>> SH;
    if (cub_sum[CW-1] && (cub_sum[SH-1:0] != '0)) begin
      scaled = scaled + CW'(1);
    end
    if (scaled > HI_LIM) begin
      height_next = HI_LIM[SAMPLE_BITS-1:0];
    end else if (scaled < LO_LIM) begin
      height_next = LO_LIM[SAMPLE_BITS-1:0];
    end else begin
      height_next = scaled[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      height_valid <= 1'b0;
    end else if (out_ready) begin
      height_valid <= cub_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      height <= height_next;
    end
  end

endmodule
`default_nettype wire
